// ===== hdl/q2e_pkg.sv =====
package q2e_pkg;

    localparam int SUM_W     = 34;
    localparam int XY_W      = 36;
    localparam int ANG_W     = 34;
    localparam int SQ_W      = 62;
    localparam int ROOT_BITS = 31;
    localparam int ATAN_LEN  = 24;

    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [SUM_W-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [15:0]      HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [15:0]      ANGLE_MAX   = 16'sd25736;

    localparam logic [ANG_W-1:0] ATAN_Q30 [ATAN_LEN] = '{
        34'h03243F6A8, 34'h01DAC6705, 34'h00FADBAFC, 34'h007F56EA6,
        34'h003FEAB76, 34'h001FFD55B, 34'h000FFFAAA, 34'h0007FFF55,
        34'h0003FFFEA, 34'h0001FFFFD, 34'h0000FFFFF, 34'h00007FFFF,
        34'h00003FFFF, 34'h00001FFFF, 34'h00000FFFF, 34'h000007FFF,
        34'h000003FFF, 34'h000001FFF, 34'h000000FFF, 34'h0000007FF,
        34'h0000003FF, 34'h0000001FF, 34'h0000000FF, 34'h00000007F
    };

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } cdc_vec_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sinr;
        logic signed [SUM_W-1:0] cosr;
        logic signed [SUM_W-1:0] siny;
        logic signed [SUM_W-1:0] cosy;
        logic signed [SUM_W-1:0] s;
        logic                    clamp;
    } side_t;

    // saturate an exact sum to signed q3.30
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd4294967295;
        lo = -36'sd4294967296;
        if (v > hi)
            sat_sum = hi[SUM_W-1:0];
        else if (v < lo)
            sat_sum = lo[SUM_W-1:0];
        else
            sat_sum = v[SUM_W-1:0];
    endfunction

endpackage

// ===== hdl/quaternion_to_euler_top.sv =====
// Quaternion to Z-Y-X Euler angles. Takes one unit quaternion word (w, x, y, z,
// signed Q1.15) per clock and returns roll and yaw in signed Q3.13 radians and
// pitch in signed Q2.13 radians, one result word per input word, in order.
// Fully pipelined: a new word is accepted every cycle while the output side
// keeps up; the pipeline is CORDIC_STAGES + 36 register stages deep. The depth
// is set by the 31-cell square root chain for the pitch cosine and the CORDIC
// chain that follows it. Roll and yaw run through their own CORDIC chains
// alongside pitch. Pitch is asin(s) evaluated as atan2(s, sqrt(1 - s^2)); when
// |s| reaches one the pitch saturates to +/- pi/2 and pitch_clamped is raised.
// A stall on the output freezes the whole pipeline; the output register holds
// its word until it is taken.
module quaternion_to_euler_top
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               quat_valid,
    output logic               quat_stall,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               euler_valid,
    input  logic               euler_stall,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               pitch_clamped
);

    // product, sum, square, sqrt cells, fold, cordic cells, round
    localparam int LAT    = 3 + ROOT_BITS + CORDIC_STAGES + 2;
    localparam int CL_DLY = CORDIC_STAGES + 2;

    logic               en;
    logic [LAT-1:0]     vld_reg;
    logic [LAT-1:0]     vld_next;

    // stage 1: products, exact q2.30
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg;
    logic signed [31:0] zx_reg, wz_reg, xy_reg, zz_reg;

    // stage 2: saturated sums
    side_t              sum_reg;
    side_t              sum_next;

    // stage 3: s squared
    side_t              side3_reg;
    logic [29:0]        mag;
    logic [59:0]        sq_reg;
    logic [59:0]        sq_next;

    // square root chain and its side band
    sqrt_st_t           sq_st [ROOT_BITS+1];
    side_t              side_reg [ROOT_BITS];
    side_t              side_out;
    logic signed [SUM_W-1:0] cos_p;

    // pitch clamp flag and sign, delayed across the cordic
    logic [CL_DLY-1:0]  cl_reg;
    logic [CL_DLY-1:0]  sg_reg;

    logic signed [15:0] roll_a, yaw_a, pitch_a;

    // whole pipeline moves unless the output word is held
    assign en         = !(vld_reg[LAT-1] && euler_stall);
    assign quat_stall = !en;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], quat_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            zz_reg <= quat_z * quat_z;
        end
    end

    // exact sums in 36 bits, then saturate to q3.30
    always_comb
    begin
        sum_next.sinr  = sat_sum((36'(wx_reg) + 36'(yz_reg)) <<< 1);
        sum_next.cosr  = sat_sum(36'(ONE_Q30) - ((36'(xx_reg) + 36'(yy_reg)) <<< 1));
        sum_next.s     = sat_sum((36'(wy_reg) - 36'(zx_reg)) <<< 1);
        sum_next.siny  = sat_sum((36'(wz_reg) + 36'(xy_reg)) <<< 1);
        sum_next.cosy  = sat_sum(36'(ONE_Q30) - ((36'(yy_reg) + 36'(zz_reg)) <<< 1));
        sum_next.clamp = (sum_next.s >= ONE_Q30) || (sum_next.s <= -ONE_Q30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_next;
    end

    // |s| < 1 when not clamped, so it fits 30 bits
    always_comb
    begin
        if (sum_reg.clamp)
            mag = '0;
        else if (sum_reg.s < 0)
            mag = 30'(-sum_reg.s);
        else
            mag = 30'(sum_reg.s);
        sq_next = mag * mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= sq_next;
            side3_reg <= sum_reg;
        end
    end

    // floor sqrt of 1 - s^2, q30
    assign sq_st[0].rem  = (SQ_W'(1) << 60) - SQ_W'(sq_reg);
    assign sq_st[0].root = '0;

    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sqrt
        q2e_sqrt_cell #(.K(ROOT_BITS - 1 - j)) u_cell (
            .clk    (clk),
            .en     (en),
            .st_in  (sq_st[j]),
            .st_out (sq_st[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side3_reg;
            for (int k = 1; k < ROOT_BITS; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    assign side_out = side_reg[ROOT_BITS-1];
    assign cos_p    = SUM_W'(sq_st[ROOT_BITS].root[ROOT_BITS-1:0]);

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (side_out.sinr),
        .x_in  (side_out.cosr),
        .angle (roll_a)
    );

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk   (clk),
        .en    (en),
        .y_in  (side_out.siny),
        .x_in  (side_out.cosy),
        .angle (yaw_a)
    );

    q2e_atan2 #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (side_out.s),
        .x_in  (cos_p),
        .angle (pitch_a)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cl_reg <= {cl_reg[CL_DLY-2:0], side_out.clamp};
            sg_reg <= {sg_reg[CL_DLY-2:0], !side_out.s[SUM_W-1]};
        end
    end

    // output word straight from the last registers
    always_comb
    begin
        roll_angle    = roll_a;
        yaw_angle     = yaw_a;
        pitch_clamped = cl_reg[CL_DLY-1];
        if (cl_reg[CL_DLY-1])
            pitch_angle = sg_reg[CL_DLY-1] ? HALF_PI_Q13[14:0] : 15'(-HALF_PI_Q13);
        else if (pitch_a > HALF_PI_Q13)
            pitch_angle = HALF_PI_Q13[14:0];
        else if (pitch_a < -HALF_PI_Q13)
            pitch_angle = 15'(-HALF_PI_Q13);
        else
            pitch_angle = pitch_a[14:0];
    end

    assign euler_valid = vld_reg[LAT-1];

    // a clamped pitch sits exactly at plus or minus pi/2
    a_clamp_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid && pitch_clamped |->
            pitch_angle == 15'sd12868 || pitch_angle == -15'sd12868)
        else $error("clamped pitch not at pi/2");

    // roll and yaw stay within +/- pi
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid |-> roll_angle <= ANGLE_MAX && roll_angle >= -ANGLE_MAX
                     && yaw_angle <= ANGLE_MAX && yaw_angle >= -ANGLE_MAX)
        else $error("angle out of range");

    // input is only held back by a held output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        quat_stall |-> euler_valid && euler_stall)
        else $error("input stalled without output stall");

    // a held output word keeps its valid into the next cycle
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid && euler_stall |=> euler_valid && $stable(roll_angle))
        else $error("held word lost");

endmodule

// ===== hdl/q2e_sqrt_cell.sv =====
module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int K = 0
)(
    input  logic     clk,
    input  logic     en,
    input  sqrt_st_t st_in,
    output sqrt_st_t st_out
);

    localparam logic [SQ_W-1:0] BIT_VAL = SQ_W'(1) << (2 * K);

    sqrt_st_t        st_reg;
    sqrt_st_t        st_next;
    logic [SQ_W-1:0] trial;

    // one result bit per cell
    always_comb
    begin
        trial = st_in.root + BIT_VAL;
        if (st_in.rem >= trial)
        begin
            st_next.rem  = st_in.rem - trial;
            st_next.root = (st_in.root >> 1) + BIT_VAL;
        end
        else
        begin
            st_next.rem  = st_in.rem;
            st_next.root = st_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            st_reg <= st_next;
    end

    assign st_out = st_reg;

endmodule

// ===== hdl/q2e_cordic_cell.sv =====
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int I = 0
)(
    input  logic     clk,
    input  logic     en,
    input  cdc_vec_t vec_in,
    output cdc_vec_t vec_out
);

    localparam logic signed [ANG_W-1:0] ATAN_I = ATAN_Q30[I];

    cdc_vec_t               vec_reg;
    cdc_vec_t               vec_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    // one vectoring micro-rotation
    always_comb
    begin
        dx       = vec_in.y >>> I;
        dy       = vec_in.x >>> I;
        vec_next = vec_in;
        if (vec_in.y > 0)
        begin
            vec_next.x = vec_in.x + dx;
            vec_next.y = vec_in.y - dy;
            vec_next.z = vec_in.z + ATAN_I;
        end
        else
        begin
            vec_next.x = vec_in.x - dx;
            vec_next.y = vec_in.y + dy;
            vec_next.z = vec_in.z - ATAN_I;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign vec_out = vec_reg;

endmodule

// ===== hdl/q2e_atan2.sv =====
module q2e_atan2
    import q2e_pkg::*;
#(
    parameter int STAGES = 16
)(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [SUM_W-1:0] y_in,
    input  logic signed [SUM_W-1:0] x_in,
    output logic signed [15:0]      angle
);

    cdc_vec_t                vec [STAGES+1];
    cdc_vec_t                pre_next;
    cdc_vec_t                pre_reg;
    logic signed [XY_W-1:0]  xe;
    logic signed [XY_W-1:0]  ye;
    logic signed [ANG_W-1:0] zc;
    logic signed [34:0]      zr;
    logic signed [17:0]      q;
    logic signed [15:0]      angle_reg;
    logic signed [15:0]      angle_next;

    // quadrant fold so the vector lies in the right half plane
    always_comb
    begin
        xe            = XY_W'(x_in);
        ye            = XY_W'(y_in);
        pre_next.x    = xe;
        pre_next.y    = ye;
        pre_next.z    = '0;
        pre_next.zero = (x_in == 0) && (y_in == 0);
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                pre_next.x = ye;
                pre_next.y = -xe;
                pre_next.z = HALF_PI_Q30;
            end
            else
            begin
                pre_next.x = -ye;
                pre_next.y = xe;
                pre_next.z = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pre_reg <= pre_next;
    end

    assign vec[0] = pre_reg;

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        q2e_cordic_cell #(.I(i)) u_cell (
            .clk     (clk),
            .en      (en),
            .vec_in  (vec[i]),
            .vec_out (vec[i+1])
        );
    end

    // clamp to +/- pi, round half up to q3.13
    always_comb
    begin
        zc = vec[STAGES].z;
        if (zc > PI_Q30)
            zc = PI_Q30;
        if (zc < -PI_Q30)
            zc = -PI_Q30;
        zr = 35'(zc) + 35'sd65536;
        q  = 18'(zr >>> 17);
        angle_next = vec[STAGES].zero ? 16'sd0 : q[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule

// ===== tb/quaternion_to_euler_top_tb.sv =====
module quaternion_to_euler_top_tb
    import q2e_pkg::*;
();

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 36;
    localparam longint SAT_HI = 64'sd4294967295;
    localparam longint SAT_LO = -64'sd4294967296;
    localparam longint ONE_FX = 64'sd1073741824;
    localparam longint PI_FX = 64'sd3373259426;
    localparam longint HALF_PI_FIX13 = 64'sd12868;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } angles_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic quat_valid = 1'b0;
    logic quat_stall;
    logic signed [15:0] quat_w = '0;
    logic signed [15:0] quat_x = '0;
    logic signed [15:0] quat_y = '0;
    logic signed [15:0] quat_z = '0;
    logic euler_valid;
    logic euler_stall = 1'b0;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic pitch_clamped;

    angles_t pending_angles[$];
    int mismatch_count = 0;
    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    int hold_off_cycles = 0;
    int stall_left = 0;

    quaternion_to_euler_top #(.CORDIC_STAGES(STAGES)) uut (
        .clk(clk), .rst_n(rst_n),
        .quat_valid(quat_valid), .quat_stall(quat_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .euler_valid(euler_valid), .euler_stall(euler_stall),
        .roll_angle(roll_angle), .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
    );

    always #5 clk = ~clk;

    // clamp an exact sum into signed q3.30
    function automatic longint clip_sum(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // atan2 by cordic vectoring, q30 radians; >>> on longint floors
    function automatic longint vector_angle(input longint yv, input longint xv);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        // left half plane: pre-rotate by a quarter turn
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                t = xv; xv = yv; yv = -t; ang = PI_FX / 2;
            end
            else
            begin
                t = xv; xv = -yv; yv = t; ang = -(PI_FX / 2);
            end
        end
        for (int i = 0; i < STAGES && i < ATAN_LEN; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv += dx; yv -= dy; ang += longint'(ATAN_Q30[i]);
            end
            else
            begin
                xv -= dx; yv += dy; ang -= longint'(ATAN_Q30[i]);
            end
        end
        if (ang > PI_FX) ang = PI_FX;
        if (ang < -PI_FX) ang = -PI_FX;
        return ang;
    endfunction

    function automatic longint round_q13(input longint a);
        return (a + 65536) >>> 17;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b; r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic angles_t euler_of(input logic signed [15:0] qw,
        input logic signed [15:0] qx, input logic signed [15:0] qy,
        input logic signed [15:0] qz);
        longint w, x, y, z, sinr, cosr, sp, siny, cosy, p;
        longint unsigned mag, c;
        angles_t r;
        w = qw; x = qx; y = qy; z = qz;
        sinr = clip_sum(2 * (w * x + y * z));
        cosr = clip_sum(ONE_FX - 2 * (x * x + y * y));
        sp = clip_sum(2 * (w * y - z * x));
        siny = clip_sum(2 * (w * z + x * y));
        cosy = clip_sum(ONE_FX - 2 * (y * y + z * z));
        r.roll = 16'(round_q13(vector_angle(sinr, cosr)));
        r.yaw = 16'(round_q13(vector_angle(siny, cosy)));
        if (sp >= ONE_FX || sp <= -ONE_FX)
        begin
            p = (sp > 0) ? HALF_PI_FIX13 : -HALF_PI_FIX13;
            r.clamped = 1'b1;
        end
        else
        begin
            mag = (sp < 0) ? -sp : sp;
            c = floor_root((64'd1 << 60) - mag * mag);
            p = round_q13(vector_angle(sp, longint'(c)));
            if (p > HALF_PI_FIX13) p = HALF_PI_FIX13;
            if (p < -HALF_PI_FIX13) p = -HALF_PI_FIX13;
            r.clamped = 1'b0;
        end
        r.pitch = 15'(p);
        return r;
    endfunction

    // offer one quaternion word and wait until it is taken; valid stays up
    // so the next word can follow at once
    task automatic send_quat(input logic signed [15:0] w, input logic signed [15:0] x,
        input logic signed [15:0] y, input logic signed [15:0] z);
        int gap;
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            quat_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        quat_valid <= 1'b1;
        quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
        pending_angles.push_back(euler_of(w, x, y, z));
        @(posedge clk);
        while (quat_stall) @(posedge clk);
    endtask

    task automatic send_random_quat();
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // unit quaternion from random axis-ish content, kept near norm one
    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = $itor($signed(16'($urandom))); b = $itor($signed(16'($urandom)));
        c = $itor($signed(16'($urandom))); d = $itor($signed(16'($urandom)));
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
            16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
    endtask

    task automatic drain_results();
        quat_valid <= 1'b0;
        while (pending_angles.size() != 0) @(posedge clk);
    endtask

    // field extremes, zero vector, negative cosine terms, gimbal lock
    task automatic test_directed();
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd32767, 16'sd0, 16'sd0, 16'sd0);
        send_quat(-16'sd32768, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd32767, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd32767, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
        send_quat(16'sd0, -16'sd32768, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
        // pitch near +/- pi/2, on both sides of the clamp
        send_quat(16'sd23170, 16'sd0, 16'sd23170, 16'sd0);
        send_quat(16'sd23170, 16'sd0, -16'sd23170, 16'sd0);
        send_quat(16'sd23170, 16'sd0, 16'sd23171, 16'sd0);
        send_quat(16'sd23170, 16'sd0, 16'sd23100, 16'sd0);
        // saturating sums, non-unit input
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
        send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_quat(16'sd23170, 16'sd23170, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd23170, 16'sd0, 16'sd23170);
        send_quat(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0) send_random_quat();
            else send_unit_quat();
        end
    endtask

    // receiver holds off long enough that the pipeline backs up into quat_stall
    task automatic test_backpressure();
        hold_off_cycles = 3 * LATENCY;
        sender_gaps = 1'b0;
        for (int i = 0; i < LATENCY + 40; i++) send_unit_quat();
        drain_results();
        sender_gaps = 1'b1;
    endtask

    task automatic test_pause_after_drain();
        test_random_mix(30);
        drain_results();
        repeat (LATENCY + 5) @(posedge clk);
        test_random_mix(30);
    endtask

    task automatic test_full_rate();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        test_random_mix(150);
    endtask

    // receiver side: stall bursts of random length, plus the hold-off from test_backpressure
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            euler_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else if (stall_left > 0)
        begin
            euler_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (receiver_gaps && $urandom_range(0, 15) == 0)
        begin
            euler_stall <= 1'b1;
            stall_left <= $urandom_range(0, 10);
        end
        else
            euler_stall <= 1'b0;
    end

    // compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin
        angles_t want;
        if (rst_n && euler_valid && !euler_stall)
        begin
            if (pending_angles.size() == 0)
            begin
                $error("result word with no prediction waiting");
                mismatch_count++;
            end
            else
            begin
                want = pending_angles.pop_front();
                if (roll_angle !== want.roll)
                begin
                    $error("roll_angle expected %0d actual %0d", want.roll, roll_angle);
                    mismatch_count++;
                end
                if (pitch_angle !== want.pitch)
                begin
                    $error("pitch_angle expected %0d actual %0d", want.pitch, pitch_angle);
                    mismatch_count++;
                end
                if (yaw_angle !== want.yaw)
                begin
                    $error("yaw_angle expected %0d actual %0d", want.yaw, yaw_angle);
                    mismatch_count++;
                end
                if (pitch_clamped !== want.clamped)
                begin
                    $error("pitch_clamped expected %0b actual %0b", want.clamped,
                        pitch_clamped);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(320);
        test_backpressure();
        test_pause_after_drain();
        test_full_rate();
        drain_results();
        repeat (LATENCY + 10) @(posedge clk);
        if (pending_angles.size() != 0)
        begin
            $error("%0d predictions never matched", pending_angles.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
